// ===== rtl/core/i2cram_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C register access master: shared package
// Field widths, configuration defaults, register indexes, command codes and
// the sequencer phase codes.
// ----------------------------------------------------------------------------
package i2cram_pkg;

  localparam int unsigned ModeW     = 2;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned DevAddrW  = 7;
  localparam int unsigned QuantumW  = 16;
  localparam int unsigned TimeoutW  = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned SubStepW  = 3;
  localparam int unsigned BitCountW = 4;

  localparam logic [DevAddrW-1:0] DevAddrReset = 7'd117;
  localparam logic [QuantumW-1:0] QuantumReset = 16'd144;
  localparam logic [TimeoutW-1:0] TimeoutReset = 8'd5;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEVICE_ADDRESS = 2'd0,
    CFG_QUANTUM_TICKS  = 2'd1,
    CFG_ACK_TIMEOUT    = 2'd2
  } cfg_idx_e;

  typedef enum logic [ModeW-1:0] {
    MODE_NONE  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2
  } mode_e;

  typedef enum logic [14:0] {
    PH_IDLE      = 15'h0001,
    PH_START_A   = 15'h0002,
    PH_SEND_DEVW = 15'h0004,
    PH_ACK_DEVW  = 15'h0008,
    PH_SEND_REG  = 15'h0010,
    PH_ACK_REG   = 15'h0020,
    PH_SEND_DATA = 15'h0040,
    PH_ACK_DATA  = 15'h0080,
    PH_START_B   = 15'h0100,
    PH_SEND_DEVR = 15'h0200,
    PH_ACK_DEVR  = 15'h0400,
    PH_RECV      = 15'h0800,
    PH_NACK      = 15'h1000,
    PH_STOP      = 15'h2000,
    PH_STOP_ERR  = 15'h4000
  } phase_e;

endpackage

// ===== rtl/core/i2cram_in_if.sv =====
// ----------------------------------------------------------------------------
// I2C register access master: input channel
// One item per bus tick: an optional command and the sampled data line.
// ----------------------------------------------------------------------------
interface i2cram_in_if;

  logic                             valid;
  logic                             ready;
  logic [i2cram_pkg::ModeW-1:0]     mode;
  logic [i2cram_pkg::ByteW-1:0]     register_address;
  logic [i2cram_pkg::ByteW-1:0]     write_value;
  logic                             sda_sample;

  modport source (
    output valid, mode, register_address, write_value, sda_sample,
    input  ready
  );

  modport sink (
    input  valid, mode, register_address, write_value, sda_sample,
    output ready
  );

endinterface

// ===== rtl/core/i2cram_out_if.sv =====
// ----------------------------------------------------------------------------
// I2C register access master: result channel
// One item per bus tick: line levels, transaction status and read data.
// ----------------------------------------------------------------------------
interface i2cram_out_if;

  logic                             valid;
  logic                             ready;
  logic                             scl_level;
  logic                             sda_level;
  logic                             sda_drive_enable;
  logic                             busy_res;
  logic                             done_res;
  logic [i2cram_pkg::ByteW-1:0]     read_value;
  logic                             no_ack;

  modport source (
    output valid, scl_level, sda_level, sda_drive_enable, busy_res, done_res,
           read_value, no_ack,
    input  ready
  );

  modport sink (
    input  valid, scl_level, sda_level, sda_drive_enable, busy_res, done_res,
           read_value, no_ack,
    output ready
  );

endinterface

// ===== rtl/core/i2c_register_access_master.sv =====
// ----------------------------------------------------------------------------
// I2C register access master
// Each accepted item advances the bus sequencer by one tick; its result item
// appears in the output register on the next cycle.
// Throughput is one item per cycle; the output register lets a new item in
// whenever the previous result is taken or the register is empty.
// Line changes are paced by the quantum counter, one sequencer step per quantum.
// Reset: sequencer idle, clock and data high and driven, defaults loaded.
// ----------------------------------------------------------------------------
module i2c_register_access_master (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [i2cram_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [i2cram_pkg::CfgDataW-1:0]     cfg_data_i,
  i2cram_in_if.sink                           in_i,
  i2cram_out_if.source                        out_o
);

  logic [i2cram_pkg::DevAddrW-1:0]  dev_addr_q;
  logic [i2cram_pkg::QuantumW-1:0]  quantum_ticks_q;
  logic [i2cram_pkg::TimeoutW-1:0]  ack_timeout_q;

  i2cram_pkg::phase_e               phase_q, phase_d;
  logic [i2cram_pkg::SubStepW-1:0]  sub_q, sub_d;
  logic [i2cram_pkg::BitCountW-1:0] bit_cnt_q, bit_cnt_d;
  logic [i2cram_pkg::ByteW-1:0]     shift_q, shift_d;
  logic [i2cram_pkg::QuantumW-1:0]  qcnt_q, qcnt_d;
  logic [i2cram_pkg::TimeoutW-1:0]  ack_wait_q, ack_wait_d;
  logic [i2cram_pkg::ByteW-1:0]     held_reg_q, held_reg_d;
  logic [i2cram_pkg::ByteW-1:0]     held_val_q, held_val_d;
  logic                             held_rd_q, held_rd_d;
  logic                             scl_q, scl_d;
  logic                             sda_q, sda_d;
  logic                             en_q, en_d;
  logic [i2cram_pkg::ByteW-1:0]     last_read_q, last_read_d;

  logic                             done;
  logic                             err;
  logic                             do_enter;
  i2cram_pkg::phase_e               enter_ph;
  logic [i2cram_pkg::QuantumW:0]    cnt_inc;
  logic [i2cram_pkg::QuantumW-1:0]  q_eff;
  logic [i2cram_pkg::BitCountW-1:0] bit_inc;

  logic                             out_valid_q;
  logic                             out_scl_q;
  logic                             out_sda_q;
  logic                             out_en_q;
  logic                             out_busy_q;
  logic                             out_done_q;
  logic [i2cram_pkg::ByteW-1:0]     out_read_q;
  logic                             out_nack_q;

  logic                             in_fire;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q      <= i2cram_pkg::DevAddrReset;
      quantum_ticks_q <= i2cram_pkg::QuantumReset;
      ack_timeout_q   <= i2cram_pkg::TimeoutReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        i2cram_pkg::CFG_DEVICE_ADDRESS: begin
          dev_addr_q <= cfg_data_i[i2cram_pkg::DevAddrW-1:0];
        end
        i2cram_pkg::CFG_QUANTUM_TICKS: begin
          quantum_ticks_q <= cfg_data_i[i2cram_pkg::QuantumW-1:0];
        end
        i2cram_pkg::CFG_ACK_TIMEOUT: begin
          ack_timeout_q <= cfg_data_i[i2cram_pkg::TimeoutW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    phase_d     = phase_q;
    sub_d       = sub_q;
    bit_cnt_d   = bit_cnt_q;
    shift_d     = shift_q;
    qcnt_d      = qcnt_q;
    ack_wait_d  = ack_wait_q;
    held_reg_d  = held_reg_q;
    held_val_d  = held_val_q;
    held_rd_d   = held_rd_q;
    scl_d       = scl_q;
    sda_d       = sda_q;
    en_d        = en_q;
    last_read_d = last_read_q;
    done        = 1'b0;
    err         = 1'b0;
    do_enter    = 1'b0;
    enter_ph    = i2cram_pkg::PH_IDLE;
    cnt_inc     = {1'b0, qcnt_q} + 17'd1;
    q_eff       = (quantum_ticks_q == '0) ? 16'd1 : quantum_ticks_q;
    bit_inc     = bit_cnt_q + 4'd1;

    if (phase_q == i2cram_pkg::PH_IDLE) begin
      if (in_i.mode inside {i2cram_pkg::MODE_WRITE, i2cram_pkg::MODE_READ}) begin
        held_reg_d = in_i.register_address;
        held_val_d = in_i.write_value;
        held_rd_d  = (in_i.mode == i2cram_pkg::MODE_READ);
        qcnt_d     = '0;
        do_enter   = 1'b1;
        enter_ph   = i2cram_pkg::PH_START_A;
      end
    end else if (cnt_inc >= {1'b0, q_eff}) begin
      qcnt_d = '0;
      case (phase_q)
        i2cram_pkg::PH_START_A, i2cram_pkg::PH_START_B: begin
          if (sub_q >= 3'd4) begin
            do_enter = 1'b1;
            enter_ph = (phase_q == i2cram_pkg::PH_START_A) ? i2cram_pkg::PH_SEND_DEVW
                                                           : i2cram_pkg::PH_SEND_DEVR;
          end else begin
            sub_d = sub_q + 3'd1;
            case (sub_q)
              3'd0:    sda_d = 1'b1;
              3'd1:    scl_d = 1'b1;
              3'd2:    sda_d = 1'b0;
              default: scl_d = 1'b0;
            endcase
          end
        end
        i2cram_pkg::PH_SEND_DEVW, i2cram_pkg::PH_SEND_REG,
        i2cram_pkg::PH_SEND_DATA, i2cram_pkg::PH_SEND_DEVR: begin
          case (sub_q)
            3'd0: begin
              sda_d = shift_q[i2cram_pkg::ByteW-1];
              sub_d = 3'd1;
            end
            3'd1: sub_d = 3'd2;
            3'd2: begin
              scl_d = 1'b1;
              sub_d = 3'd3;
            end
            3'd3: begin
              shift_d   = {shift_q[i2cram_pkg::ByteW-2:0], 1'b0};
              bit_cnt_d = bit_inc;
              scl_d     = 1'b0;
              sub_d     = (bit_inc >= 4'd8) ? 3'd4 : 3'd0;
            end
            default: begin
              do_enter = 1'b1;
              case (phase_q)
                i2cram_pkg::PH_SEND_DEVW: enter_ph = i2cram_pkg::PH_ACK_DEVW;
                i2cram_pkg::PH_SEND_REG:  enter_ph = i2cram_pkg::PH_ACK_REG;
                i2cram_pkg::PH_SEND_DATA: enter_ph = i2cram_pkg::PH_ACK_DATA;
                default:                  enter_ph = i2cram_pkg::PH_ACK_DEVR;
              endcase
            end
          endcase
        end
        i2cram_pkg::PH_ACK_DEVW, i2cram_pkg::PH_ACK_REG,
        i2cram_pkg::PH_ACK_DATA, i2cram_pkg::PH_ACK_DEVR: begin
          case (sub_q)
            3'd0: sub_d = 3'd1;
            3'd1: begin
              scl_d = 1'b1;
              sub_d = 3'd2;
            end
            3'd2, 3'd3: begin
              if (!in_i.sda_sample) begin
                en_d  = 1'b1;
                sda_d = 1'b0;
                sub_d = 3'd4;
              end else if (ack_wait_q >= ack_timeout_q) begin
                sub_d = 3'd5;
              end else begin
                ack_wait_d = ack_wait_q + 8'd1;
                sub_d      = 3'd3;
              end
            end
            3'd4: begin
              do_enter = 1'b1;
              case (phase_q)
                i2cram_pkg::PH_ACK_DEVW: enter_ph = i2cram_pkg::PH_SEND_REG;
                i2cram_pkg::PH_ACK_REG: begin
                  enter_ph = held_rd_q ? i2cram_pkg::PH_START_B : i2cram_pkg::PH_SEND_DATA;
                end
                i2cram_pkg::PH_ACK_DATA: enter_ph = i2cram_pkg::PH_STOP;
                default:                 enter_ph = i2cram_pkg::PH_RECV;
              endcase
            end
            default: begin
              do_enter = 1'b1;
              enter_ph = i2cram_pkg::PH_STOP_ERR;
            end
          endcase
        end
        i2cram_pkg::PH_RECV: begin
          case (sub_q)
            3'd0: sub_d = 3'd1;
            3'd1: begin
              scl_d = 1'b1;
              sub_d = 3'd2;
            end
            3'd2: begin
              shift_d   = {shift_q[i2cram_pkg::ByteW-2:0], in_i.sda_sample};
              bit_cnt_d = bit_inc;
              scl_d     = 1'b0;
              sub_d     = (bit_inc >= 4'd8) ? 3'd3 : 3'd0;
            end
            default: begin
              last_read_d = shift_q;
              do_enter    = 1'b1;
              enter_ph    = i2cram_pkg::PH_NACK;
            end
          endcase
        end
        i2cram_pkg::PH_NACK: begin
          case (sub_q)
            3'd0: begin
              scl_d = 1'b1;
              sub_d = 3'd1;
            end
            3'd1: begin
              scl_d = 1'b0;
              sub_d = 3'd2;
            end
            default: begin
              do_enter = 1'b1;
              enter_ph = i2cram_pkg::PH_STOP;
            end
          endcase
        end
        i2cram_pkg::PH_STOP, i2cram_pkg::PH_STOP_ERR: begin
          case (sub_q)
            3'd0: begin
              sda_d = 1'b0;
              sub_d = 3'd1;
            end
            3'd1: begin
              scl_d = 1'b1;
              sub_d = 3'd2;
            end
            3'd2: begin
              sda_d = 1'b1;
              sub_d = 3'd3;
            end
            default: begin
              done    = 1'b1;
              err     = (phase_q == i2cram_pkg::PH_STOP_ERR);
              phase_d = i2cram_pkg::PH_IDLE;
              sub_d   = '0;
            end
          endcase
        end
        default: begin
          phase_d = i2cram_pkg::PH_IDLE;
          sub_d   = '0;
        end
      endcase
    end else begin
      qcnt_d = cnt_inc[i2cram_pkg::QuantumW-1:0];
    end

    // Entry actions of the phase being entered.
    if (do_enter) begin
      phase_d = enter_ph;
      sub_d   = '0;
      case (enter_ph)
        i2cram_pkg::PH_START_A, i2cram_pkg::PH_START_B,
        i2cram_pkg::PH_STOP, i2cram_pkg::PH_STOP_ERR: begin
          en_d  = 1'b1;
          scl_d = 1'b0;
        end
        i2cram_pkg::PH_SEND_DEVW: begin
          shift_d   = {dev_addr_q, 1'b0};
          bit_cnt_d = '0;
          scl_d     = 1'b0;
        end
        i2cram_pkg::PH_SEND_DEVR: begin
          shift_d   = {dev_addr_q, 1'b1};
          bit_cnt_d = '0;
          scl_d     = 1'b0;
        end
        i2cram_pkg::PH_SEND_REG: begin
          shift_d   = held_reg_q;
          bit_cnt_d = '0;
          scl_d     = 1'b0;
        end
        i2cram_pkg::PH_SEND_DATA: begin
          shift_d   = held_val_q;
          bit_cnt_d = '0;
          scl_d     = 1'b0;
        end
        i2cram_pkg::PH_ACK_DEVW, i2cram_pkg::PH_ACK_REG,
        i2cram_pkg::PH_ACK_DATA, i2cram_pkg::PH_ACK_DEVR: begin
          ack_wait_d = '0;
          en_d       = 1'b0;
        end
        i2cram_pkg::PH_RECV: begin
          bit_cnt_d = '0;
          shift_d   = '0;
          en_d      = 1'b0;
          scl_d     = 1'b0;
        end
        i2cram_pkg::PH_NACK: begin
          en_d  = 1'b1;
          sda_d = 1'b1;
        end
        default: begin
          phase_d = i2cram_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= i2cram_pkg::PH_IDLE;
      sub_q       <= '0;
      bit_cnt_q   <= '0;
      shift_q     <= '0;
      qcnt_q      <= '0;
      ack_wait_q  <= '0;
      held_reg_q  <= '0;
      held_val_q  <= '0;
      held_rd_q   <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      en_q        <= 1'b1;
      last_read_q <= '0;
    end else if (in_fire) begin
      phase_q     <= phase_d;
      sub_q       <= sub_d;
      bit_cnt_q   <= bit_cnt_d;
      shift_q     <= shift_d;
      qcnt_q      <= qcnt_d;
      ack_wait_q  <= ack_wait_d;
      held_reg_q  <= held_reg_d;
      held_val_q  <= held_val_d;
      held_rd_q   <= held_rd_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      en_q        <= en_d;
      last_read_q <= last_read_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_scl_q  <= scl_d;
      out_sda_q  <= sda_d;
      out_en_q   <= en_d;
      out_busy_q <= (phase_d != i2cram_pkg::PH_IDLE);
      out_done_q <= done;
      out_read_q <= last_read_d;
      out_nack_q <= done && err;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.scl_level        = out_scl_q;
  assign out_o.sda_level        = out_sda_q;
  assign out_o.sda_drive_enable = out_en_q;
  assign out_o.busy_res         = out_busy_q;
  assign out_o.done_res         = out_done_q;
  assign out_o.read_value       = out_read_q;
  assign out_o.no_ack           = out_nack_q;

endmodule
